>>> hw/rtl/hue_selective_saturation_core_defines.svh
// assertion macros for the core rtl file
`ifndef HUE_SELECTIVE_SATURATION_CORE_DEFINES_SVH
`define HUE_SELECTIVE_SATURATION_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define HSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define HSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSS_ASSERT(label, clk, rst, prop, msg)
`define HSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hw/rtl/hss_pkg.sv
`timescale 1ns / 1ps

package hss_pkg;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [2:0] field_index;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // color plus bypass flag, carried alongside the datapath
   typedef struct packed {
      req_type pix;
      logic    pass;
   } side_type;

   typedef enum logic [2:0] {
      CSR_BAND_STARTS,
      CSR_BAND_ENDS,
      CSR_BAND_SCALES,
      CSR_FIELD_SATS,
      CSR_HUE_SCALED,
      CSR_FIELD_ENABLES
   } csr_index_type;

   localparam int CSR_DATA_W = 60;
   localparam int BANDS_W    = 56;
   localparam int FIELDS_W   = 5;
   localparam int GAIN_W     = 12;

   localparam logic [BANDS_W-1:0]    SCALES_RESET = 56'h40404040404040;
   localparam logic [CSR_DATA_W-1:0] SATS_RESET   = 60'h100100100100100;
   localparam logic [FIELDS_W-1:0]   HUE_SCALED_RESET = 5'd5;
   localparam logic [FIELDS_W-1:0]   ENABLES_RESET    = 5'd31;

   localparam int ONE_Q8     = 256;
   localparam int ONE_Q12    = 4096;
   localparam int HUE_CIRCLE = 65280;
   localparam int GAIN_MAX   = 4095;
   localparam int LUMA_R     = 1225;
   localparam int LUMA_G     = 2404;
   localparam int LUMA_B     = 467;
   localparam int HALF_Q12   = 2048;
   localparam int HALF_Q20   = 524288;
   localparam int WEIGHT_MAX = 16320;

   // divider geometries
   localparam int HUE_NUM_W = 27;
   localparam int HUE_DEN_W = 11;
   localparam int HUE_QUO_W = 16;
   localparam int W_NUM_W   = 28;
   localparam int W_DEN_W   = 16;
   localparam int W_QUO_W   = 13;
   localparam int HW_QUO_W  = 14;

   function automatic logic [7:0] band_byte(input logic [BANDS_W-1:0] bytes,
                                            input logic [2:0] idx);
      logic [63:0] ext;
      ext = {8'd0, bytes};
      return ext[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [GAIN_W-1:0] field_gain(input logic [CSR_DATA_W-1:0] sats,
                                                    input logic [2:0] idx);
      logic [63:0] ext;
      logic [5:0]  pos;
      ext = {4'd0, sats};
      pos = 6'(idx) * 6'd12;
      if (idx > 3'd4) begin
         return '0;
      end
      return ext[pos +: GAIN_W];
   endfunction

   function automatic logic field_bit(input logic [FIELDS_W-1:0] bits,
                                      input logic [2:0] idx);
      if (idx > 3'd4) begin
         return 1'b0;
      end
      return bits[idx];
   endfunction

   // round q20 to an 8-bit channel with clamping
   function automatic logic [7:0] clamp_q20(input logic signed [34:0] v);
      logic [34:0] t;
      logic [14:0] q;
      t = 35'(v) + 35'(HALF_Q20);
      q = t[34:20];
      if (v < 0) begin
         return 8'd0;
      end
      if (q > 15'd255) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

endpackage

>>> hw/rtl/hue_selective_saturation_core.sv
// channel  dir  handshake           payload
// req      in   req_valid/req_stall hss_pkg::req_type (rgb + field index)
// rsp      out  rsp_valid/rsp_stall hss_pkg::rsp_type (adjusted rgb)
// csr      in   csr_write           csr_index, csr_data (write only)
//
// one beat per cycle in and out unless rsp_stall backs up into req_stall; with the default
// geometry most pipeline stages are the three divider cell chains (16 + 13 + 14 cells)
// synchronous active-high reset clears valid bits and loads the csr registers with their reset values
// a stalled result sits in the output register while the pipe keeps filling;
// req_stall rises only once a beat reaches the last stage behind it
`timescale 1ns / 1ps
`include "hue_selective_saturation_core_defines.svh"

module hue_selective_saturation_core #(
   parameter int HUE_BANDS    = 7,
   parameter int LIGHT_FIELDS = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  hss_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output hss_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write,
   input  logic [2:0]                         csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0]     csr_data
);
   import hss_pkg::*;

   // pipeline positions
   localparam int HUE_END    = HUE_QUO_W;
   localparam int BAND_ST    = HUE_END + 1;
   localparam int WDIV_END   = BAND_ST + W_QUO_W;
   localparam int PROD_ST    = WDIV_END + 1;
   localparam int SUM_ST     = PROD_ST + 1;
   localparam int HWDIV_END  = SUM_ST + HW_QUO_W;
   localparam int GAIN_ST    = HWDIV_END + 1;
   localparam int LUMA_ST    = GAIN_ST + 1;
   localparam int DEPTH      = LUMA_ST + 1;
   localparam int ACC_W      = 20 + $clog2(HUE_BANDS);
   localparam int WSUM_W     = 13 + $clog2(HUE_BANDS);
   localparam int HW_NUM_W   = ACC_W + 6;

   // csr registers
   logic [BANDS_W-1:0]    starts_ff;
   logic [BANDS_W-1:0]    ends_ff;
   logic [BANDS_W-1:0]    scales_ff;
   logic [CSR_DATA_W-1:0] sats_ff;
   logic [FIELDS_W-1:0]   hue_scaled_ff;
   logic [FIELDS_W-1:0]   enables_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         starts_ff     <= '0;
         ends_ff       <= '0;
         scales_ff     <= SCALES_RESET;
         sats_ff       <= SATS_RESET;
         hue_scaled_ff <= HUE_SCALED_RESET;
         enables_ff    <= ENABLES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BAND_STARTS:   starts_ff     <= csr_data[BANDS_W-1:0];
            CSR_BAND_ENDS:     ends_ff       <= csr_data[BANDS_W-1:0];
            CSR_BAND_SCALES:   scales_ff     <= csr_data[BANDS_W-1:0];
            CSR_FIELD_SATS:    sats_ff       <= csr_data;
            CSR_HUE_SCALED:    hue_scaled_ff <= csr_data[FIELDS_W-1:0];
            CSR_FIELD_ENABLES: enables_ff    <= csr_data[FIELDS_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // sideband line: color and bypass flag travel with the beat
   side_type side_ff  [DEPTH+1];
   logic     valid_ff [DEPTH+1];
   side_type side_in;

   // flow control: the whole pipe moves unless a finished beat is blocked
   logic     adv;
   logic     out_valid_ff;
   rsp_type  out_ff;
   logic     out_hold;

   assign out_hold  = out_valid_ff && rsp_stall;
   assign adv       = !(valid_ff[DEPTH] && out_hold);
   assign req_stall = !adv;

   always_comb begin
      side_in.pix  = req_payload;
      // bypass: field out of range, field disabled, or gray
      side_in.pass = (32'(req_payload.field_index) >= LIGHT_FIELDS) ||
                     !field_bit(enables_ff, req_payload.field_index) ||
                     (req_payload.red_in == req_payload.green_in &&
                      req_payload.green_in == req_payload.blue_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k <= DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= DEPTH; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // hue sector numerator and divisor
   logic [7:0]           hr, hg, hb;
   logic [7:0]           hmx, hmn, hdl;
   logic [10:0]          hdl6;
   logic [10:0]          hn;
   logic [HUE_NUM_W-1:0] hue_num;
   logic [HUE_DEN_W-1:0] hue_den;
   logic [HUE_QUO_W-1:0] hue_q;

   always_comb begin
      hr  = side_ff[0].pix.red_in;
      hg  = side_ff[0].pix.green_in;
      hb  = side_ff[0].pix.blue_in;
      hmx = hr;
      hmn = hr;
      if (hg > hmx) begin
         hmx = hg;
      end
      if (hb > hmx) begin
         hmx = hb;
      end
      if (hg < hmn) begin
         hmn = hg;
      end
      if (hb < hmn) begin
         hmn = hb;
      end
      hdl  = hmx - hmn;
      hdl6 = 11'(hdl) * 11'd6;
      // ties go to red, then green
      if (hmx == hr) begin
         hn = (hg >= hb) ? 11'(hg - hb) : (hdl6 - 11'(hb - hg));
      end else if (hmx == hg) begin
         hn = 11'(hdl) * 11'd2 + 11'(hb) - 11'(hr);
      end else begin
         hn = 11'(hdl) * 11'd4 + 11'(hr) - 11'(hg);
      end
      // n * 65280 as two shifts
      hue_num = (HUE_NUM_W'(hn) << 16) - (HUE_NUM_W'(hn) << 8);
      hue_den = (hdl == 8'd0) ? HUE_DEN_W'(1) : hdl6;
   end

   hss_div_pipe #(
      .NUM_W (HUE_NUM_W),
      .DEN_W (HUE_DEN_W),
      .QUO_W (HUE_QUO_W)
   ) u_hue_div (
      .clock (clock),
      .en    (adv),
      .num   (hue_num),
      .den   (hue_den),
      .quo   (hue_q)
   );

   // per band window weight
   logic [W_NUM_W-1:0] w_num [HUE_BANDS];
   logic [W_DEN_W-1:0] w_den [HUE_BANDS];
   logic [W_QUO_W-1:0] w_q   [HUE_BANDS];

   for (genvar i = 0; i < HUE_BANDS; i++) begin : g_band
      hss_band_cell u_band (
         .clock      (clock),
         .en         (adv),
         .hue        (hue_q),
         .band_start (band_byte(starts_ff, 3'(i))),
         .band_end   (band_byte(ends_ff, 3'(i))),
         .num_ff     (w_num[i]),
         .den_ff     (w_den[i])
      );

      hss_div_pipe #(
         .NUM_W (W_NUM_W),
         .DEN_W (W_DEN_W),
         .QUO_W (W_QUO_W)
      ) u_wdiv (
         .clock (clock),
         .en    (adv),
         .num   (w_num[i]),
         .den   (w_den[i]),
         .quo   (w_q[i])
      );
   end

   // scale times weight per band, then the two sums
   logic [19:0]        prod_ff [HUE_BANDS];
   logic [W_QUO_W-1:0] wt_ff   [HUE_BANDS];
   logic [ACC_W-1:0]   acc_in, acc_ff;
   logic [WSUM_W-1:0]  wsum_in, wsum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < HUE_BANDS; i++) begin
            prod_ff[i] <= 20'(21'(band_byte(scales_ff, 3'(i))) * 21'(w_q[i]));
            wt_ff[i]   <= w_q[i];
         end
      end
   end

   always_comb begin
      acc_in  = '0;
      wsum_in = '0;
      for (int i = 0; i < HUE_BANDS; i++) begin
         acc_in  = acc_in + ACC_W'(prod_ff[i]);
         wsum_in = wsum_in + WSUM_W'(wt_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff  <= acc_in;
         wsum_ff <= wsum_in;
      end
   end

   // hue weight: weighted mean of scales, unity when no band hits
   logic [HW_NUM_W-1:0] hw_num;
   logic [WSUM_W-1:0]   hw_den;
   logic [HW_QUO_W-1:0] hw_q;

   always_comb begin
      if (wsum_ff == '0) begin
         hw_num = HW_NUM_W'(ONE_Q12);
         hw_den = WSUM_W'(1);
      end else begin
         hw_num = {acc_ff, 6'd0};
         hw_den = wsum_ff;
      end
   end

   hss_div_pipe #(
      .NUM_W (HW_NUM_W),
      .DEN_W (WSUM_W),
      .QUO_W (HW_QUO_W)
   ) u_hw_div (
      .clock (clock),
      .en    (adv),
      .num   (hw_num),
      .den   (hw_den),
      .quo   (hw_q)
   );

   // final gain
   logic [2:0]        gf;
   logic [GAIN_W-1:0] fgain;
   logic [25:0]       gprod;
   logic [26:0]       grnd;
   logic [14:0]       gscaled;
   logic [GAIN_W-1:0] gain_in, gain_ff;
   logic              unity_in, unity_ff;

   always_comb begin
      gf      = side_ff[HWDIV_END].pix.field_index;
      fgain   = field_gain(sats_ff, gf);
      gprod   = 26'(fgain) * 26'(hw_q);
      grnd    = 27'(gprod) + 27'(HALF_Q12);
      gscaled = grnd[26:12];
      gain_in = fgain;
      if (field_bit(hue_scaled_ff, gf)) begin
         gain_in = (gscaled > 15'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : gscaled[GAIN_W-1:0];
      end
      unity_in = gain_in == GAIN_W'(ONE_Q8);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gain_ff  <= gain_in;
         unity_ff <= unity_in;
      end
   end

   // luma and per channel distance from it
   logic [7:0]         lc      [3];
   logic [19:0]        luma_in, luma_ff;
   logic signed [20:0] diff_in [3];
   logic signed [20:0] diff_ff [3];
   logic [GAIN_W-1:0]  gain_l_ff;
   logic               unity_l_ff;

   always_comb begin
      lc[0]   = side_ff[GAIN_ST].pix.red_in;
      lc[1]   = side_ff[GAIN_ST].pix.green_in;
      lc[2]   = side_ff[GAIN_ST].pix.blue_in;
      luma_in = 20'(lc[0]) * 20'(LUMA_R) + 20'(lc[1]) * 20'(LUMA_G) +
                20'(lc[2]) * 20'(LUMA_B);
      for (int c = 0; c < 3; c++) begin
         diff_in[c] = $signed({1'b0, lc[c], 12'd0}) - $signed({1'b0, luma_in});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         luma_ff    <= luma_in;
         diff_ff    <= diff_in;
         gain_l_ff  <= gain_ff;
         unity_l_ff <= unity_ff;
      end
   end

   // v = luma * 256 + diff * gain, q20
   logic signed [33:0] mprod [3];
   logic signed [34:0] v_in  [3];
   logic signed [34:0] v_ff  [3];
   logic               unity_m_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mprod[c] = diff_ff[c] * $signed({1'b0, gain_l_ff});
         v_in[c]  = 35'(mprod[c]) + $signed({7'd0, luma_ff, 8'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff       <= v_in;
         unity_m_ff <= unity_l_ff;
      end
   end

   // output register
   rsp_type out_in;

   always_comb begin
      if (side_ff[DEPTH].pass || unity_m_ff) begin
         out_in.red_out   = side_ff[DEPTH].pix.red_in;
         out_in.green_out = side_ff[DEPTH].pix.green_in;
         out_in.blue_out  = side_ff[DEPTH].pix.blue_in;
      end else begin
         out_in.red_out   = clamp_q20(v_ff[0]);
         out_in.green_out = clamp_q20(v_ff[1]);
         out_in.blue_out  = clamp_q20(v_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         out_valid_ff <= valid_ff[DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `HSS_ASSERT(a_out_fill, clock, reset, (valid_ff[DEPTH] && !out_hold) |=> out_valid_ff, "finished beat not taken into output register")
   `HSS_ASSERT(a_hue_range, clock, reset, (valid_ff[HUE_END] && !side_ff[HUE_END].pass) |-> (hue_q < 16'(HUE_CIRCLE)), "hue beyond circle")
   `HSS_ASSERT(a_weight_range, clock, reset, valid_ff[HWDIV_END] |-> (hw_q <= 14'(WEIGHT_MAX)), "hue weight above largest scale")
   `HSS_ASSERT(a_pass_copy, clock, reset, (valid_ff[DEPTH] && side_ff[DEPTH].pass && !out_hold) |=> (rsp_payload.green_out == $past(side_ff[DEPTH].pix.green_in)), "bypass beat altered")
   `HSS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

>>> hw/rtl/hss_div_cell.sv
`timescale 1ns / 1ps

// one restoring step: subtract the shifted divisor if it fits
module hss_div_cell #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11,
   parameter int QUO_W = 16,
   parameter int STEP  = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] rem_up,
   input  logic [DEN_W-1:0] den_up,
   input  logic [QUO_W-1:0] quo_up,
   output logic [NUM_W-1:0] rem_ff,
   output logic [DEN_W-1:0] den_ff,
   output logic [QUO_W-1:0] quo_ff
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CMP_W-1:0] rem_ext;
   logic [CMP_W-1:0] sub_ext;
   logic             fits;
   logic [NUM_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_in;

   always_comb begin
      rem_ext = CMP_W'(rem_up);
      sub_ext = CMP_W'(den_up) << STEP;
      fits    = rem_ext >= sub_ext;
      rem_in  = rem_up;
      quo_in  = quo_up;
      if (fits) begin
         rem_in       = NUM_W'(rem_ext - sub_ext);
         quo_in[STEP] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_up;
         quo_ff <= quo_in;
      end
   end

endmodule

>>> hw/rtl/hss_div_pipe.sv
`timescale 1ns / 1ps

// chain of division cells, one quotient bit per cell, msb first
module hss_div_pipe #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0] rem_w [QUO_W+1];
   logic [DEN_W-1:0] den_w [QUO_W+1];
   logic [QUO_W-1:0] quo_w [QUO_W+1];

   assign rem_w[0] = num;
   assign den_w[0] = den;
   assign quo_w[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      hss_div_cell #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W),
         .QUO_W (QUO_W),
         .STEP  (QUO_W - 1 - k)
      ) u_cell (
         .clock  (clock),
         .en     (en),
         .rem_up (rem_w[k]),
         .den_up (den_w[k]),
         .quo_up (quo_w[k]),
         .rem_ff (rem_w[k+1]),
         .den_ff (den_w[k+1]),
         .quo_ff (quo_w[k+1])
      );
   end

   assign quo = quo_w[QUO_W];

endmodule

>>> hw/rtl/hss_band_cell.sv
`timescale 1ns / 1ps

// triangular window setup for one hue band: dividend and divisor of its weight
module hss_band_cell (
   input  logic                             clock,
   input  logic                             en,
   input  logic [15:0]                      hue,
   input  logic [7:0]                       band_start,
   input  logic [7:0]                       band_end,
   output logic [hss_pkg::W_NUM_W-1:0]      num_ff,
   output logic [hss_pkg::W_DEN_W-1:0]      den_ff
);
   import hss_pkg::*;

   logic                full;
   logic [7:0]          st;
   logic [8:0]          wrap;
   logic [7:0]          span;
   logic [15:0]         big_s;
   logic [16:0]         diff;
   logic [15:0]         ofs;
   logic                skip;
   logic [16:0]         two;
   logic [16:0]         ofs_dist;
   logic [15:0]         height;
   logic [W_NUM_W-1:0]  num_in;
   logic [W_DEN_W-1:0]  den_in;

   always_comb begin
      full = (band_start == 8'd0 && band_end == 8'hFF) ||
             (band_start == 8'hFF && band_end == 8'd0);
      st   = (band_start == 8'hFF) ? 8'd0 : band_start;
      wrap = {1'b0, band_end} + 9'd255 - {1'b0, band_start};
      if (wrap >= 9'd510) begin
         span = 8'd0;
      end else if (wrap >= 9'd255) begin
         span = 8'(wrap - 9'd255);
      end else begin
         span = wrap[7:0];
      end
      big_s = {span, 8'd0};
      // offset from the band start around the circle
      diff = {1'b0, hue} - {1'b0, st, 8'd0};
      ofs  = diff[16] ? 16'(diff + 17'(HUE_CIRCLE)) : diff[15:0];
      skip = (span == 8'd0) || (ofs > big_s);
      two  = {ofs, 1'b0};
      ofs_dist = (two >= {1'b0, big_s}) ? (two - {1'b0, big_s}) : ({1'b0, big_s} - two);
      height = big_s - ofs_dist[15:0];
      if (full) begin
         num_in = W_NUM_W'(ONE_Q12);
         den_in = W_DEN_W'(1);
      end else if (skip) begin
         num_in = '0;
         den_in = W_DEN_W'(1);
      end else begin
         num_in = {height, 12'd0};
         den_in = big_s;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

endmodule

>>> verif/hue_selective_saturation_core_test.sv
`timescale 1ns / 1ps

module hue_selective_saturation_core_test;
   import hss_pkg::*;

   localparam int LATENCY     = 50;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_BEATS = 1950;

   // expected colors queue, checked in order
   class color_scoreboard;
      rsp_type pending[$];
      int      errors;

      function void note(rsp_type exp_color);
         pending = {pending, exp_color};
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %s: got %0d want %0d", what, got, want);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected beat", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.red_out !== want.red_out) report("red", got.red_out, want.red_out);
         if (got.green_out !== want.green_out)
            report("green", got.green_out, want.green_out);
         if (got.blue_out !== want.blue_out) report("blue", got.blue_out, want.blue_out);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   color_scoreboard board = new();
   int cycles = 0;
   bit hold_off = 0;
   bit random_stall = 1;

   // model copy of the registers
   logic [55:0] m_starts, m_ends, m_scales;
   logic [59:0] m_sats;
   logic [4:0]  m_hue_scaled, m_enables;

   always #10 clock = ~clock;

   hue_selective_saturation_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // hue weight in q2.12 from the seven triangular bands
   function automatic longint calc_hue_weight(int r, int g, int b);
      int mx, mn, dl, n, hue, s, e, sc, st, span, bs, o, a;
      longint wsum, acc, w;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dl = mx - mn;
      if (mx == r) n = (g >= b) ? g - b : 6 * dl - (b - g);
      else if (mx == g) n = 2 * dl + b - r;
      else n = 4 * dl + r - g;
      hue = (n * 65280) / (6 * dl);
      wsum = 0; acc = 0;
      for (int i = 0; i < 7; i++) begin
         s = m_starts[8*i +: 8];
         e = m_ends[8*i +: 8];
         sc = m_scales[8*i +: 8];
         if ((s == 0 && e == 255) || (s == 255 && e == 0)) begin
            wsum += 4096;
            acc += sc * 4096;
            continue;
         end
         st = s % 255;
         span = (e + 255 - s) % 255;
         if (span == 0) continue;
         bs = span * 256;
         o = (hue + 65280 - st * 256) % 65280;
         if (o > bs) continue;
         a = (2 * o >= bs) ? 2 * o - bs : bs - 2 * o;
         w = (longint'(bs - a) * 4096) / bs;
         wsum += w;
         acc += sc * w;
      end
      if (wsum == 0) return 4096;
      return (acc * 64) / wsum;
   endfunction

   function automatic int adjust_channel(int c, longint luma, longint gain);
      longint v, q;
      v = luma * 256 + (longint'(c) * 4096 - luma) * gain;
      if (v < 0) return 0;
      q = (v + (1 << 19)) >>> 20;
      return q > 255 ? 255 : int'(q);
   endfunction

   function automatic rsp_type predict_color(req_type px);
      rsp_type o;
      int r, g, b, f;
      longint gain, p, luma;
      r = px.red_in; g = px.green_in; b = px.blue_in; f = px.field_index;
      o = {px.red_in, px.green_in, px.blue_in};
      // out-of-range field, disabled field, gray: pass through
      if (f >= 5) return o;
      if (!m_enables[f]) return o;
      if (r == g && g == b) return o;
      gain = m_sats[12*f +: 12];
      if (m_hue_scaled[f]) begin
         p = (gain * calc_hue_weight(r, g, b) + 2048) >>> 12;
         gain = p > 4095 ? 4095 : p;
      end
      if (gain == 256) return o;
      luma = 1225 * r + 2404 * g + 467 * b;
      o.red_out = 8'(adjust_channel(r, luma, gain));
      o.green_out = 8'(adjust_channel(g, luma, gain));
      o.blue_out = 8'(adjust_channel(b, luma, gain));
      return o;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check(rsp_payload);
      end
   end

   // receiver: stall at random or hold off on request
   initial begin : stall_driver
      int w;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else if (random_stall && ($urandom_range(0, 3) == 0)) begin
            w = $urandom_range(0, 16);
            if (w == 0) rsp_stall <= 1'b0;
            else begin
               rsp_stall <= 1'b1;
               repeat (w - 1) @(posedge clock);
            end
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [59:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_BAND_STARTS:   m_starts = val[55:0];
         CSR_BAND_ENDS:     m_ends = val[55:0];
         CSR_BAND_SCALES:   m_scales = val[55:0];
         CSR_FIELD_SATS:    m_sats = val;
         CSR_HUE_SCALED:    m_hue_scaled = val[4:0];
         CSR_FIELD_ENABLES: m_enables = val[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // offer one beat, hold it until accepted; valid drops only for a gap
   task automatic send_color(req_type px, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (req_stall);
      board.note(predict_color(px));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mostly valid fields, sometimes the unused codes
   function automatic req_type rand_color();
      req_type px;
      px.red_in = 8'($urandom()); px.green_in = 8'($urandom()); px.blue_in = 8'($urandom());
      if ($urandom_range(0, 9) == 0) px.blue_in = px.red_in;
      if ($urandom_range(0, 19) == 0) begin
         px.green_in = px.red_in; px.blue_in = px.red_in;
      end
      px.field_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      return px;
   endfunction

   // random band layout with some full circles and wraps
   task automatic random_setup();
      logic [55:0] st, en;
      st = 56'(rand64()); en = 56'(rand64());
      for (int i = 0; i < 7; i++) begin
         if ($urandom_range(0, 6) == 0) begin
            st[8*i +: 8] = 8'd0; en[8*i +: 8] = 8'd255;
         end else if ($urandom_range(0, 9) == 0) begin
            st[8*i +: 8] = 8'd255; en[8*i +: 8] = 8'd0;
         end
      end
      write_reg(CSR_BAND_STARTS, 60'(st));
      write_reg(CSR_BAND_ENDS, 60'(en));
      write_reg(CSR_BAND_SCALES, 60'(rand64()));
      write_reg(CSR_FIELD_SATS, 60'(rand64()));
      write_reg(CSR_HUE_SCALED, 60'($urandom_range(0, 31)));
      write_reg(CSR_FIELD_ENABLES, 60'($urandom_range(0, 31)));
   endtask

   initial begin : main
      req_type px;
      m_starts = '0; m_ends = '0; m_scales = SCALES_RESET; m_sats = SATS_RESET;
      m_hue_scaled = HUE_SCALED_RESET; m_enables = ENABLES_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes, gray, unused fields
      send_color('{8'd255, 8'd0, 8'd0, 3'd0}, 0);
      send_color('{8'd0, 8'd255, 8'd0, 3'd1}, 0);
      send_color('{8'd0, 8'd0, 8'd255, 3'd2}, 0);
      send_color('{8'd128, 8'd128, 8'd128, 3'd0}, 0);
      send_color('{8'd0, 8'd0, 8'd0, 3'd3}, 0);
      send_color('{8'd10, 8'd200, 8'd30, 3'd7}, 0);
      send_color('{8'd10, 8'd200, 8'd30, 3'd5}, 0);
      drain();
      // full-circle bands, max gain and scale, enables toggled
      write_reg(CSR_BAND_STARTS, 60'h00ff00ff00ff00);
      write_reg(CSR_BAND_ENDS, 60'hff00ff00ff00ff);
      write_reg(CSR_BAND_SCALES, 60'hffffffffffffff);
      write_reg(CSR_FIELD_SATS, 60'hfff000fff080200);
      write_reg(CSR_HUE_SCALED, 60'd31);
      write_reg(CSR_FIELD_ENABLES, 60'd26);
      for (int f = 0; f < 5; f++) begin
         send_color('{8'd255, 8'd0, 8'd128, 3'(f)}, 0);
         send_color('{8'd1, 8'd254, 8'd255, 3'(f)}, 1);
      end
      drain();
      // all zero bands, gain zero, hue scaling off
      write_reg(CSR_BAND_STARTS, 60'h0);
      write_reg(CSR_BAND_ENDS, 60'h0);
      write_reg(CSR_BAND_SCALES, 60'h0);
      write_reg(CSR_FIELD_SATS, 60'h0);
      write_reg(CSR_HUE_SCALED, 60'd0);
      write_reg(CSR_FIELD_ENABLES, 60'd31);
      send_color('{8'd255, 8'd128, 8'd0, 3'd0}, 0);
      send_color('{8'd0, 8'd255, 8'd255, 3'd4}, 0);
      drain();

      // random phases
      for (int ph = 0; ph < 13; ph++) begin
         random_setup();
         if (ph == 4) begin
            // long receiver hold-off so the pipe fills and req_stall rises
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(posedge clock);
                  hold_off = 0;
               end
               for (int i = 0; i < 150; i++) send_color(rand_color(), 0);
            join
         end else begin
            random_stall = (ph % 3 != 2);
            for (int i = 0; i < RANDOM_BEATS / 13; i++) begin
               send_color(rand_color(), ($urandom_range(0, 3) == 0)
                                        ? $urandom_range(0, 16) : 0);
               // sender pause until everything is back
               if (i == 40) drain();
            end
            random_stall = 1;
         end
         drain();
      end

      if (board.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hss_pkg.sv
hw/rtl/hss_div_cell.sv
hw/rtl/hss_div_pipe.sv
hw/rtl/hss_band_cell.sv
hw/rtl/hue_selective_saturation_core.sv
verif/hue_selective_saturation_core_test.sv
